FILE: rtl/b64hd_pkg.sv
// Shared types, codes and character lookups for the base64 / hex stream decoder.
package b64hd_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3d;

    localparam logic REG_DECODE_MODE = 1'b0;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_BAD_LENGTH    = 3'd1,
        ST_MISPLACED_PAD = 3'd2,
        ST_BROKEN_PAD    = 3'd3,
        ST_INVALID_CHAR  = 3'd4
    } status_t;

    typedef enum logic {
        MODE_BASE64 = 1'b0,
        MODE_HEX    = 1'b1
    } mode_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        status_t    status;
    } result_t;

    typedef struct packed {
        logic    byte_valid;
        result_t byte_item;
        logic    status_valid;
        result_t status_item;
    } step_out_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } lookup_t;

    function automatic lookup_t b64_lookup(input logic [7:0] c);
        lookup_t r;
        r.ok    = 1'b1;
        r.value = 6'd0;
        if (c inside {[8'h41:8'h5a]})
        begin
            r.value = 6'(c - 8'h41);
        end
        else if (c inside {[8'h61:8'h7a]})
        begin
            r.value = 6'(c - 8'h61 + 8'd26);
        end
        else if (c inside {[8'h30:8'h39]})
        begin
            r.value = 6'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2b)
        begin
            r.value = 6'd62;
        end
        else if (c == 8'h2f)
        begin
            r.value = 6'd63;
        end
        else
        begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    function automatic lookup_t hex_lookup(input logic [7:0] c);
        lookup_t r;
        r.ok    = 1'b1;
        r.value = 6'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            r.value = 6'(c - 8'h30);
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            r.value = 6'(c - 8'h41 + 8'd10);
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            r.value = 6'(c - 8'h61 + 8'd10);
        end
        else
        begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: rtl/base64_hex_stream_decoder_core.sv
// Top level of the base64 / hex stream decoder: input register, APB register, result queue.
//
//   channel   signals                                    direction
//   input     in_valid, in_ready, in_char, last_char     in
//   output    out_valid, out_ready, out_byte,
//             is_status, status                          out
//   config    psel, penable, pwrite, paddr, pwdata,
//             prdata, pready                             in / out
//
// One character per cycle unless stalled: it waits in the input register, where the
// decode step runs and pushes its byte and/or end status into a four-entry queue.
// A character whose string ends with a byte gives two results; the queue drains one
// per cycle while out_ready is high. The input register stalls while fewer than two
// queue slots are free. Reset clears string state, queue and mode register (base64).
module base64_hex_stream_decoder_core import b64hd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_char,
    input  logic        last_char,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        is_status,
    output logic [2:0]  status,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg;
    logic       last_reg;
    mode_t      mode_reg, mode_next;

    logic       in_accept;
    logic       advance;
    logic       has_room;
    step_out_t  step_out;
    result_t    head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DECODE_MODE) ? {31'd0, mode_reg} : 32'd0;

    always_comb
    begin
        mode_next = mode_reg;
        if (psel && penable && pwrite && pready && paddr[2] == REG_DECODE_MODE)
        begin
            mode_next = mode_t'(pwdata[0]);
        end
    end

    assign advance   = in_valid_reg && has_room;
    assign in_ready  = !in_valid_reg || advance;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_BASE64;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            mode_reg     <= mode_next;
        end
    end

    // hold payload until the next transfer
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_char_reg <= in_char;
            last_reg    <= last_char;
        end
    end

    b64hd_step u_step
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_char     (in_char_reg),
        .last_char   (last_reg),
        .decode_mode (mode_reg),
        .step_out    (step_out)
    );

    b64hd_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .step_out  (step_out),
        .has_room  (has_room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign out_byte  = head.out_byte;
    assign is_status = head.is_status;
    assign status    = head.status;

endmodule

FILE: rtl/b64hd_step.sv
// Per-character decode step: group position, held bits, pad fact and first error.
module b64hd_step import b64hd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  logic [7:0] in_char,
    input  logic      last_char,
    input  mode_t     decode_mode,
    output step_out_t step_out
);

    logic [1:0] pos_reg,  pos_next;
    logic [5:0] held_reg, held_next;
    logic       pad3_reg, pad3_next;
    status_t    err_reg,  err_next;

    lookup_t    b64;
    lookup_t    hex;
    status_t    err;
    status_t    first_err;
    logic       have;
    logic [7:0] byte_val;
    logic       len_ok;

    always_comb
    begin
        b64       = b64_lookup(in_char);
        hex       = hex_lookup(in_char);
        err       = ST_OK;
        have      = 1'b0;
        byte_val  = 8'd0;
        len_ok    = 1'b0;
        pos_next  = pos_reg;
        held_next = held_reg;
        pad3_next = pad3_reg;

        if (decode_mode == MODE_BASE64)
        begin
            pad3_next = (pos_reg == 2'd0) ? 1'b0 : pad3_reg;
            if (in_char == PAD_CHAR)
            begin
                if (pos_reg < 2'd2)
                begin
                    err = ST_MISPLACED_PAD;
                end
                else if (pos_reg == 2'd2)
                begin
                    pad3_next = 1'b1;
                end
                else if (!last_char)
                begin
                    err = ST_MISPLACED_PAD;
                end
                held_next = 6'd0;
            end
            else
            begin
                if (pos_reg == 2'd3 && pad3_next)
                begin
                    err = last_char ? ST_BROKEN_PAD : ST_MISPLACED_PAD;
                end
                else if (!b64.ok)
                begin
                    err = ST_INVALID_CHAR;
                end
                if (err == ST_OK)
                begin
                    case (pos_reg)
                        2'd1:
                        begin
                            have     = 1'b1;
                            byte_val = {held_reg, b64.value[5:4]};
                        end
                        2'd2:
                        begin
                            have     = 1'b1;
                            byte_val = {held_reg[3:0], b64.value[5:2]};
                        end
                        2'd3:
                        begin
                            have     = 1'b1;
                            byte_val = {held_reg[1:0], b64.value};
                        end
                        default:
                        begin
                            have = 1'b0;
                        end
                    endcase
                end
                held_next = b64.value;
            end
            len_ok   = (pos_reg == 2'd3);
            pos_next = pos_reg + 2'd1;
        end
        else
        begin
            pad3_next = 1'b0;
            if (!hex.ok)
            begin
                err = ST_INVALID_CHAR;
            end
            else if (pos_reg[0])
            begin
                have     = 1'b1;
                byte_val = {held_reg[3:0], hex.value[3:0]};
            end
            held_next = {2'b00, hex.value[3:0]};
            len_ok    = pos_reg[0];
            pos_next  = pos_reg[0] ? 2'd0 : 2'd1;
        end

        first_err = (err != ST_OK && err_reg == ST_OK) ? err : err_reg;
        err_next  = first_err;

        step_out.byte_valid            = have && (first_err == ST_OK);
        step_out.byte_item.out_byte    = byte_val;
        step_out.byte_item.is_status   = 1'b0;
        step_out.byte_item.status      = ST_OK;
        step_out.status_valid          = last_char;
        step_out.status_item.out_byte  = 8'd0;
        step_out.status_item.is_status = 1'b1;
        step_out.status_item.status    = len_ok ? first_err : ST_BAD_LENGTH;

        if (last_char)
        begin
            pos_next  = 2'd0;
            held_next = 6'd0;
            pad3_next = 1'b0;
            err_next  = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 2'd0;
            held_reg <= 6'd0;
            pad3_reg <= 1'b0;
            err_reg  <= ST_OK;
        end
        else if (advance)
        begin
            pos_reg  <= pos_next;
            held_reg <= held_next;
            pad3_reg <= pad3_next;
            err_reg  <= err_next;
        end
    end

endmodule

FILE: rtl/b64hd_outq.sv
// Result queue: takes up to two results per cycle, hands out one per transfer.
module b64hd_outq import b64hd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  step_out_t step_out,
    output logic      has_room,
    output logic      out_valid,
    input  logic      out_ready,
    output result_t   head
);

    result_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg,  count_next;
    logic [QCNT_W-1:0]   n_push;
    logic                pop;
    result_t             first_item;
    logic [QPTR_W-1:0]   wr_ptr_plus1;

    always_comb
    begin
        n_push = '0;
        if (push)
        begin
            n_push = QCNT_W'(step_out.byte_valid) + QCNT_W'(step_out.status_valid);
        end
        first_item   = step_out.byte_valid ? step_out.byte_item : step_out.status_item;
        wr_ptr_plus1 = wr_ptr_reg + QPTR_W'(1);
        pop          = out_valid && out_ready;
        wr_ptr_next  = wr_ptr_reg + n_push[QPTR_W-1:0];
        rd_ptr_next  = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next   = count_reg + n_push - QCNT_W'(pop);
    end

    assign out_valid = (count_reg != '0);
    assign has_room  = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (n_push != '0)
        begin
            entry_reg[wr_ptr_reg] <= first_item;
        end
        if (n_push == QCNT_W'(2))
        begin
            entry_reg[wr_ptr_plus1] <= step_out.status_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: verif/base64_hex_stream_decoder_core_tb.sv
// Self-checking testbench for the base64 / hex stream decoder core.
module base64_hex_stream_decoder_core_tb import b64hd_pkg::*;
;

    localparam logic [2:0] ADDR_DECODE_MODE = {REG_DECODE_MODE, 2'b00};
    localparam int         SETTLE_CYCLES    = 8;
    localparam int         TAIL_CYCLES      = 16;
    localparam int         HOLD_OFF_CYCLES  = 80;
    localparam int         WATCHDOG_LIMIT   = 2000;
    localparam int         PRINT_CAP        = 50;

    typedef logic [7:0] char_q_t[$];

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  in_char   = 8'h00;
    logic        last_char = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        is_status;
    logic [2:0]  status;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = 3'd0;
    logic [31:0] pwdata    = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    mode_t       model_mode     = MODE_BASE64;
    logic [1:0]  group_pos      = 2'd0;
    logic [5:0]  held_value     = 6'd0;
    logic        pad_third      = 1'b0;
    logic        pad_fourth     = 1'b0;
    status_t     earliest_error = ST_OK;
    result_t     decode_results_due[$];

    int          mismatches   = 0;
    int          chars_sent   = 0;
    bit          steady       = 1'b0;
    bit          hold_request = 1'b0;

    base64_hex_stream_decoder_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_char   (in_char),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .is_status (is_status),
        .status    (status),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [6:0] sextet_of(input logic [7:0] ch);
        if (ch >= "A" && ch <= "Z")
            return {1'b1, 6'(ch - "A")};
        if (ch >= "a" && ch <= "z")
            return {1'b1, 6'(ch - "a" + 26)};
        if (ch >= "0" && ch <= "9")
            return {1'b1, 6'(ch - "0" + 52)};
        if (ch == "+")
            return {1'b1, 6'd62};
        if (ch == "/")
            return {1'b1, 6'd63};
        return 7'd0;
    endfunction

    function automatic logic [6:0] nibble_of(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9")
            return {1'b1, 6'(ch - "0")};
        if (ch >= "A" && ch <= "F")
            return {1'b1, 6'(ch - "A" + 10)};
        if (ch >= "a" && ch <= "f")
            return {1'b1, 6'(ch - "a" + 10)};
        return 7'd0;
    endfunction

    function automatic logic [7:0] b64_symbol(input int idx);
        if (idx < 26)
            return 8'("A" + idx);
        if (idx < 52)
            return 8'("a" + idx - 26);
        if (idx < 62)
            return 8'("0" + idx - 52);
        if (idx == 62)
            return "+";
        return "/";
    endfunction

    function automatic logic [7:0] hex_symbol(input int nib, input bit upper);
        if (nib < 10)
            return 8'("0" + nib);
        return upper ? 8'("A" + nib - 10) : 8'("a" + nib - 10);
    endfunction

    function automatic char_q_t chars_of(input string txt);
        char_q_t seq;
        int i;
        for (i = 0; i < txt.len(); i++)
            seq.push_back(txt[i]);
        return seq;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void decode_char(input logic [7:0] ch, input logic fin);
        logic [1:0] pos;
        logic [6:0] look;
        logic [5:0] val;
        status_t    err;
        logic [7:0] data;
        logic       have;
        logic       len_ok;
        result_t    item;
        pos  = group_pos;
        err  = ST_OK;
        data = 8'h00;
        have = 1'b0;
        if (model_mode == MODE_BASE64)
        begin
            if (pos == 2'd0)
            begin
                pad_third  = 1'b0;
                pad_fourth = 1'b0;
            end
            if (ch == PAD_CHAR)
            begin
                if (pos < 2'd2)
                    err = ST_MISPLACED_PAD;
                else if (pos == 2'd2)
                    pad_third = 1'b1;
                else
                begin
                    pad_fourth = 1'b1;
                    if (!fin)
                        err = ST_MISPLACED_PAD;
                end
                held_value = 6'd0;
            end
            else
            begin
                look = sextet_of(ch);
                val  = look[5:0];
                if (pos == 2'd3 && pad_third)
                    err = fin ? ST_BROKEN_PAD : ST_MISPLACED_PAD;
                else if (!look[6])
                    err = ST_INVALID_CHAR;
                if (err == ST_OK)
                begin
                    case (pos)
                        2'd1:
                        begin
                            data = {held_value, val[5:4]};
                            have = 1'b1;
                        end
                        2'd2:
                        begin
                            data = {held_value[3:0], val[5:2]};
                            have = 1'b1;
                        end
                        2'd3:
                        begin
                            data = {held_value[1:0], val};
                            have = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                held_value = val;
            end
            len_ok    = (pos == 2'd3);
            group_pos = pos + 2'd1;
        end
        else
        begin
            look       = nibble_of(ch);
            val        = look[5:0];
            pad_third  = 1'b0;
            pad_fourth = 1'b0;
            if (!look[6])
                err = ST_INVALID_CHAR;
            else if (pos[0])
            begin
                data = {held_value[3:0], val[3:0]};
                have = 1'b1;
            end
            held_value = {2'b00, val[3:0]};
            len_ok     = pos[0];
            group_pos  = pos[0] ? 2'd0 : 2'd1;
        end

        if (err != ST_OK && earliest_error == ST_OK)
            earliest_error = err;

        if (have && earliest_error == ST_OK)
        begin
            item.out_byte  = data;
            item.is_status = 1'b0;
            item.status    = ST_OK;
            decode_results_due.push_back(item);
        end

        if (fin)
        begin
            item.out_byte  = 8'h00;
            item.is_status = 1'b1;
            item.status    = len_ok ? earliest_error : ST_BAD_LENGTH;
            decode_results_due.push_back(item);
            group_pos      = 2'd0;
            held_value     = 6'd0;
            pad_third      = 1'b0;
            pad_fourth     = 1'b0;
            earliest_error = ST_OK;
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    task automatic send_char(input logic [7:0] ch, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_char   <= ch;
        last_char <= fin;
        do
            @(posedge clk);
        while (!in_ready);
        decode_char(ch, fin);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_seq(input char_q_t seq, input logic close);
        int k;
        for (k = 0; k < seq.size(); k++)
            send_char(seq[k], close && (k == seq.size() - 1));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (decode_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_mode(input mode_t m);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_DECODE_MODE;
        pwdata  <= ($urandom() & 32'hffff_fffe) | 32'(m);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        model_mode = m;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_random_string();
        char_q_t seq;
        int      pick;
        int      n;
        int      where;
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            n = $urandom_range(1, 8);
            repeat (n) seq.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            if (model_mode == MODE_BASE64)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 3);
                repeat (4 * n) seq.push_back(b64_symbol($urandom_range(0, 63)));
                case ($urandom_range(0, 2))
                    1:
                    begin
                        seq[seq.size() - 1] = PAD_CHAR;
                    end
                    2:
                    begin
                        seq[seq.size() - 1] = PAD_CHAR;
                        seq[seq.size() - 2] = PAD_CHAR;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
                repeat (2 * n)
                    seq.push_back(hex_symbol($urandom_range(0, 15), $urandom_range(0, 1)));
            end
            if (pick >= 75)
            begin
                where = $urandom_range(0, seq.size() - 1);
                case ($urandom_range(0, 4))
                    0: seq[where] = 8'($urandom_range(0, 255));
                    1: seq[where] = PAD_CHAR;
                    2: void'(seq.pop_back());
                    3: seq.push_back(seq[where]);
                    default: seq[where] = seq[where] ^ (8'h01 << $urandom_range(0, 7));
                endcase
            end
        end
        send_seq(seq, 1'b1);
    endtask

    task automatic test_base64_groups();
        char_q_t seq;
        write_mode(MODE_BASE64);
        send_seq(chars_of("////"), 1'b1);
        send_seq(chars_of("+9A="), 1'b1);
        send_seq(chars_of("AB=C"), 1'b1);
        seq = '{8'h41, 8'h80, 8'h42, 8'h00};
        send_seq(seq, 1'b1);
        send_seq(chars_of("AB="), 1'b1);
        send_seq(chars_of("="), 1'b1);
        settle();
    endtask

    task automatic test_mode_switch_mid_string();
        send_seq(chars_of("Zm"), 1'b0);
        settle();
        write_mode(MODE_HEX);
        send_seq(chars_of("9F"), 1'b1);
        settle();
    endtask

    task automatic test_hex_pairs();
        send_seq(chars_of("fF0a"), 1'b1);
        send_seq(chars_of("0g"), 1'b1);
        send_seq(chars_of("A"), 1'b1);
        settle();
    endtask

    task automatic test_random_strings();
        int phase;
        int target;
        for (phase = 0; phase < 12; phase++)
        begin
            write_mode((phase % 2 == 0) ? MODE_BASE64 : MODE_HEX);
            steady = (phase % 4 == 3);
            target = chars_sent + 125;
            while (chars_sent < target)
                send_random_string();
            settle();
        end
        steady = 1'b0;
    endtask

    task automatic test_output_hold_off();
        int target;
        write_mode(MODE_BASE64);
        steady       = 1'b1;
        hold_request = 1'b1;
        target       = chars_sent + 40;
        while (chars_sent < target)
            send_random_string();
        steady = 1'b0;
        settle();
    endtask

    initial
    begin : receiver
        int stall;
        stall = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall        = HOLD_OFF_CYCLES;
            end
            else if (stall == 0)
                stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (decode_results_due.size() == 0)
                report_mismatch($sformatf("unexpected transfer byte=%02h is_status=%0b status=%0d",
                                          out_byte, is_status, status));
            else
            begin
                want = decode_results_due.pop_front();
                if (out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              out_byte, want.out_byte));
                if (is_status !== want.is_status)
                    report_mismatch($sformatf("is_status %0b, want %0b",
                                              is_status, want.is_status));
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", status, want.status));
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_base64_groups();
        test_mode_switch_mid_string();
        test_hex_pairs();
        test_random_strings();
        test_output_hold_off();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (decode_results_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", decode_results_due.size()));
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
rtl/b64hd_pkg.sv
rtl/b64hd_step.sv
rtl/b64hd_outq.sv
rtl/base64_hex_stream_decoder_core.sv
verif/base64_hex_stream_decoder_core_tb.sv
